@@ design/derb_pkg.sv @@
`timescale 1ns / 1ps

package derb_pkg;

	// Storage geometry.
	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Fixed field widths of the stream and configuration ports.
	localparam int OP_W      = 3;
	localparam int WORD_W    = 32;
	localparam int INDEX_W   = 8;
	localparam int CFG_W     = 9;
	localparam int COUNT_W   = 9;
	localparam int IN_DATA_W = 40;
	localparam int OUT_RAW_W = WORD_W + COUNT_W + 3;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(256);

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_item;
		logic execute;
		logic load_out;
	} derb_cmd_t;

endpackage

@@ design/derb_ctrl.sv @@
`timescale 1ns / 1ps

module derb_ctrl
	import derb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output derb_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d       = state_q;
		cmd.take_item = 1'b0;
		cmd.execute   = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/derb_dpath.sv @@
`timescale 1ns / 1ps

module derb_dpath
	import derb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  derb_cmd_t             cmd,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [OP_W-1:0]       s_tuser,
	input  logic                  cfg_write,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// (a + b) mod cap, both operands below cap.
	function automatic logic [CNT_W-1:0] ring_add(
		input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b,
		input logic [CNT_W-1:0] cap
	);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[CNT_W-1:0];
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [CFG_W-1:0]  capacity_q;
	logic [ADDR_W-1:0] front_q;
	logic [CNT_W-1:0]  fill_q;

	logic [OP_W-1:0]    op_q;
	logic [WORD_W-1:0]  din_q;
	logic [INDEX_W-1:0] idx_q;

	logic [DATA_WIDTH-1:0] rd_q;
	logic [CNT_W-1:0]      res_count_q;
	logic                  res_full_q;
	logic                  res_empty_q;
	logic                  res_err_q;
	logic                  res_use_rd_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  front_ext;
	logic [CNT_W-1:0]  logical;
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] front_inc;
	logic [ADDR_W-1:0] front_d;
	logic [CNT_W-1:0]  fill_d;
	logic              wr_en;
	logic              use_rd;
	logic              err;
	logic [WORD_W-1:0] data_out;

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > 32'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	assign front_ext = CNT_W'(front_q);
	assign front_inc = ADDR_W'(ring_add(front_ext, CNT_W'(1), cap_eff));
	assign addr      = ADDR_W'(ring_add(front_ext, logical, cap_eff));

	always_comb begin
		logical = '0;
		front_d = front_q;
		fill_d  = fill_q;
		wr_en   = 1'b0;
		use_rd  = 1'b0;
		err     = 1'b0;
		unique case (op_q)
			OP_PUSH_BACK: begin
				wr_en = 1'b1;
				if (fill_q < cap_eff) begin
					logical = fill_q;
					fill_d  = fill_q + CNT_W'(1);
				end else begin
					front_d = front_inc;
				end
			end
			OP_PUSH_FRONT: begin
				wr_en   = 1'b1;
				logical = cap_eff - CNT_W'(1);
				front_d = addr;
				if (fill_q < cap_eff) begin
					fill_d = fill_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (fill_q == '0) begin
					err = 1'b1;
				end else begin
					logical = fill_q - CNT_W'(1);
					use_rd  = 1'b1;
					fill_d  = fill_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (fill_q == '0) begin
					err = 1'b1;
				end else begin
					use_rd  = 1'b1;
					front_d = front_inc;
					fill_d  = fill_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (32'(idx_q) >= 32'(fill_q)) begin
					err = 1'b1;
				end else begin
					logical = CNT_W'(idx_q);
					use_rd  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Pointer state and the capacity register; a capacity write empties the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			front_q    <= '0;
			fill_q     <= '0;
		end else if (cfg_write) begin
			capacity_q <= cfg_data;
			front_q    <= '0;
			fill_q     <= '0;
		end else if (cmd.execute) begin
			front_q <= front_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (wr_en) begin
				mem[addr] <= DATA_WIDTH'(din_q);
			end
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q  <= s_tuser;
			din_q <= s_tdata[WORD_W-1:0];
			idx_q <= s_tdata[WORD_W +: INDEX_W];
		end
		if (cmd.execute) begin
			res_count_q  <= fill_d;
			res_full_q   <= (fill_d == cap_eff);
			res_empty_q  <= (fill_d == '0);
			res_err_q    <= err;
			res_use_rd_q <= use_rd;
		end
		if (cmd.load_out) begin
			m_tdata_q <= OUT_DATA_W'({res_err_q, res_empty_q, res_full_q,
				COUNT_W'(res_count_q), data_out});
		end
	end

	assign data_out = res_use_rd_q ? WORD_W'(rd_q) : '0;
	assign m_tdata  = m_tdata_q;

endmodule

@@ design/double_ended_ring_buffer.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: data_in, index; tuser: op
// m_*       out        m_tvalid / m_tready  tdata: data_out, count, full, empty, error
// cfg_*     in         cfg_valid / cfg_ready  capacity (9 bits)
//
// Each operation passes through acceptance, the slot access on the single memory
// port with the pointer update, and the load of the output register, which waits
// until that register is free. The result register lets the next transaction be
// accepted while an earlier result still waits on m_tready. The asynchronous
// reset empties the ring and sets the capacity to 256; slot contents are not cleared.

module double_ended_ring_buffer
	import derb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: data_in [31:0], index [39:32].
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Fields from bit 0: op [2:0].
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Fields from bit 0: data_out [31:0], count [40:32], is_full [41],
	// is_empty [42], error [43]; bits above are zero.
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	derb_cmd_t cmd;

	// The capacity register is always ready; a write clears the ring pointers.
	assign cfg_ready = 1'b1;

	derb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the slot memory, the front and fill pointers, the
	// latched transaction and the output register.
	derb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule
